### rtl/core/epid_pkg.sv
// epid_pkg: shared types and constants for the encoder position PID block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none
package epid_pkg;

    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned INTEG_W  = 17;
    localparam int unsigned DERIV_W  = 33;
    localparam int unsigned KP_PW    = 49;
    localparam int unsigned KI_PW    = 34;
    localparam int unsigned KD_PW    = 50;
    localparam int unsigned SUM_W    = 51;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [15:0] KP_RESET    = 16'd3277;
    localparam logic [15:0] KI_RESET    = 16'd819;
    localparam logic [15:0] KD_RESET    = 16'd410;
    localparam logic [15:0] LIMIT_RESET = 16'd1000;
    localparam logic [15:0] MIN_RESET   = 16'd300;
    localparam logic [7:0]  TOL_RESET   = 8'd5;

    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_STOP = 2'd2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP     = 3'd0,
        REG_KI     = 3'd1,
        REG_KD     = 3'd2,
        REG_LIMIT  = 3'd3,
        REG_MIN    = 3'd4,
        REG_TARGET = 3'd5,
        REG_INVERT = 3'd6,
        REG_TOL    = 3'd7
    } epid_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]       kp_gain;
        logic [GAIN_W-1:0]       ki_gain;
        logic [GAIN_W-1:0]       kd_gain;
        logic [GAIN_W-1:0]       drive_limit;
        logic [GAIN_W-1:0]       min_drive;
        logic signed [POS_W-1:0] target_position;
        logic                    count_invert;
        logic [7:0]              arrive_tolerance;
    } epid_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
        logic                      stop;
        logic [1:0]                dir;
        logic signed [POS_W-1:0]   position;
    } epid_err_t;

    typedef struct packed {
        logic signed [KP_PW-1:0] kp_prod;
        logic signed [KI_PW-1:0] ki_prod;
        logic signed [KD_PW-1:0] kd_prod;
        logic                    stop;
        logic [1:0]              dir;
        logic signed [POS_W-1:0] position;
    } epid_prod_t;

endpackage
`default_nettype wire

### rtl/core/epid_state.sv
// epid_state: counter difference, position, error, integral and derivative stage.
// Holds the loop state registers; depends on epid_pkg.
`default_nettype none
module epid_state #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire epid_pkg::epid_cfg_t       cfg,
    input  wire logic                      in_valid,
    input  wire logic [COUNTER_WIDTH-1:0]  in_counter,
    input  wire logic                      in_start,
    output logic                           in_ready,
    output logic                           st_valid,
    output epid_pkg::epid_err_t            st_data,
    input  wire logic                      st_ready
);
    import epid_pkg::*;

    logic                      valid_reg;
    epid_err_t                 data_reg;
    logic [COUNTER_WIDTH-1:0]  last_count_reg;
    logic signed [POS_W-1:0]   position_reg;
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [POS_W-1:0]   prev_err_reg;
    logic                      done_reg;

    logic                      take;
    logic [COUNTER_WIDTH-1:0]  last_base;
    logic signed [POS_W-1:0]   pos_base;
    logic signed [INTEG_W-1:0] integ_base;
    logic signed [POS_W-1:0]   prev_base;
    logic                      done_base;
    logic [COUNTER_WIDTH-1:0]  cnt_delta;
    logic signed [POS_W-1:0]   diff_ext;
    logic signed [POS_W-1:0]   diff;
    logic signed [POS_W-1:0]   pos_new;
    logic signed [POS_W:0]     err_full;
    logic signed [POS_W-1:0]   err_sat;
    logic signed [POS_W:0]     isum;
    logic signed [POS_W:0]     lim_ext;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [POS_W:0]     tol_ext;
    logic                      arrive;
    epid_err_t                 data_next;

    assign in_ready = !valid_reg || st_ready;
    assign take     = in_valid && in_ready;

    assign last_base  = in_start ? in_counter : last_count_reg;
    assign pos_base   = in_start ? '0 : position_reg;
    assign integ_base = in_start ? '0 : integral_reg;
    assign prev_base  = in_start ? '0 : prev_err_reg;
    assign done_base  = in_start ? 1'b0 : done_reg;

    assign cnt_delta = in_counter - last_base;
    assign diff_ext  = POS_W'(signed'(cnt_delta));
    assign diff      = cfg.count_invert ? -diff_ext : diff_ext;
    assign pos_new   = pos_base + diff;

    assign err_full = {cfg.target_position[POS_W-1], cfg.target_position}
                    - {pos_new[POS_W-1], pos_new};

    always_comb begin
        if (err_full[POS_W] != err_full[POS_W-1]) begin
            err_sat = err_full[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            err_sat = err_full[POS_W-1:0];
        end
    end

    assign isum    = {{(POS_W+1-INTEG_W){integ_base[INTEG_W-1]}}, integ_base}
                   + {err_sat[POS_W-1], err_sat};
    assign lim_ext = {{(POS_W+1-GAIN_W){1'b0}}, cfg.drive_limit};

    always_comb begin
        priority if (isum > lim_ext) begin
            integ_new = lim_ext[INTEG_W-1:0];
        end else if (isum < -lim_ext) begin
            integ_new = INTEG_W'(-lim_ext);
        end else begin
            integ_new = isum[INTEG_W-1:0];
        end
    end

    assign deriv   = {err_sat[POS_W-1], err_sat} - {prev_base[POS_W-1], prev_base};
    assign tol_ext = {{(POS_W+1-8){1'b0}}, cfg.arrive_tolerance};
    assign arrive  = (err_full < tol_ext) && (err_full > -tol_ext);

    always_comb begin
        data_next.err      = err_sat;
        data_next.integ    = integ_new;
        data_next.deriv    = deriv;
        data_next.stop     = done_base || arrive;
        data_next.dir      = (err_full > 0) ? DIR_FWD : DIR_REV;
        data_next.position = done_base ? pos_base : pos_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            last_count_reg <= '0;
            position_reg   <= '0;
            integral_reg   <= '0;
            prev_err_reg   <= '0;
            done_reg       <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (take && !done_base) begin
                last_count_reg <= in_counter;
                position_reg   <= pos_new;
                integral_reg   <= integ_new;
                prev_err_reg   <= err_sat;
                done_reg       <= arrive;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= data_next;
        end
    end

    assign st_valid = valid_reg;
    assign st_data  = data_reg;

    // once arrived, position holds until a new move starts
    a_frozen_after_arrival: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && !(take && in_start) |=> $stable(position_reg))
        else $error("position moved after arrival");

endmodule
`default_nettype wire

### rtl/core/epid_mul.sv
// epid_mul: gain multiplication stage, three products registered.
// Depends on epid_pkg.
`default_nettype none
module epid_mul (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire epid_pkg::epid_cfg_t  cfg,
    input  wire logic                 in_valid,
    input  wire epid_pkg::epid_err_t  in_data,
    output logic                      in_ready,
    output logic                      prod_valid,
    output epid_pkg::epid_prod_t      prod_data,
    input  wire logic                 prod_ready
);
    import epid_pkg::*;

    logic       valid_reg;
    epid_prod_t data_reg;
    epid_prod_t data_next;

    assign in_ready = !valid_reg || prod_ready;

    always_comb begin
        data_next.kp_prod  = signed'({1'b0, cfg.kp_gain}) * in_data.err;
        data_next.ki_prod  = signed'({1'b0, cfg.ki_gain}) * in_data.integ;
        data_next.kd_prod  = signed'({1'b0, cfg.kd_gain}) * in_data.deriv;
        data_next.stop     = in_data.stop;
        data_next.dir      = in_data.dir;
        data_next.position = in_data.position;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign prod_valid = valid_reg;
    assign prod_data  = data_reg;

endmodule
`default_nettype wire

### rtl/core/epid_drive.sv
// epid_drive: PID sum, output clamp and drive shaping into the result register.
// Depends on epid_pkg.
`default_nettype none
module epid_drive #(
    parameter int unsigned GAIN_FRACTION_BITS = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire epid_pkg::epid_cfg_t  cfg,
    input  wire logic                 in_valid,
    input  wire epid_pkg::epid_prod_t in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    output logic [15:0]               out_magnitude,
    output logic [1:0]                out_direction,
    output logic                      out_arrived,
    output logic signed [31:0]        out_position,
    input  wire logic                 out_ready
);
    import epid_pkg::*;

    logic                     valid_reg;
    logic [GAIN_W-1:0]        mag_reg;
    logic [1:0]               dir_reg;
    logic                     arrived_reg;
    logic signed [POS_W-1:0]  pos_reg;

    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  slim;
    logic signed [SUM_W-1:0]  sum_clamped;
    logic [SUM_W-1:0]         absum;
    logic [SUM_W-1:0]         mag_full;
    logic [GAIN_W-1:0]        mag_raw;
    logic [GAIN_W-1:0]        mag_next;

    assign in_ready = !valid_reg || out_ready;

    assign sum = SUM_W'(in_data.kp_prod) + SUM_W'(in_data.ki_prod) + SUM_W'(in_data.kd_prod);
    assign slim = signed'(SUM_W'(cfg.drive_limit) << GAIN_FRACTION_BITS);

    always_comb begin
        priority if (sum > slim) begin
            sum_clamped = slim;
        end else if (sum < -slim) begin
            sum_clamped = -slim;
        end else begin
            sum_clamped = sum;
        end
    end

    assign absum    = sum_clamped[SUM_W-1] ? unsigned'(-sum_clamped) : unsigned'(sum_clamped);
    assign mag_full = absum >> GAIN_FRACTION_BITS;
    assign mag_raw  = mag_full[GAIN_W-1:0];

    always_comb begin
        priority if (mag_raw < cfg.min_drive) begin
            mag_next = cfg.min_drive;
        end else if (mag_raw > cfg.drive_limit) begin
            mag_next = cfg.drive_limit;
        end else begin
            mag_next = mag_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mag_reg     <= in_data.stop ? '0 : mag_next;
            dir_reg     <= in_data.stop ? DIR_STOP : in_data.dir;
            arrived_reg <= in_data.stop;
            pos_reg     <= in_data.position;
        end
    end

    assign out_valid     = valid_reg;
    assign out_magnitude = mag_reg;
    assign out_direction = dir_reg;
    assign out_arrived   = arrived_reg;
    assign out_position  = pos_reg;

endmodule
`default_nettype wire

### rtl/core/encoder_position_pid.sv
// encoder_position_pid: top level of the encoder position PID controller.
// Holds configuration and input registers; uses epid_pkg, epid_state, epid_mul, epid_drive.
//
// Usage:
//  - Input beats (s_valid/s_ready) carry one raw quadrature counter sample per control
//    tick and a start_move flag that zeroes position, integral and history.
//  - Result beats (m_valid/m_ready) carry drive magnitude, direction (forward, reverse,
//    stop), the arrival flag and the accumulated position; one result per input beat.
//  - Configuration: cfg_wr_en, cfg_index, cfg_wdata; a write lands on the clock edge with
//    cfg_wr_en high. Write only while no beat is in flight.
//  - Pipeline: four register stages (input, state update, gain products, result).
//  - Throughput: one beat per cycle while m_ready takes results; the position/integral
//    update closes its loop in the state stage.
//  - Stalls: each stage advances when the next is empty or moving, so a held result
//    still lets up to three further beats in before s_ready drops.
//  - Reset (aresetn low, synchronous) empties the pipeline, clears position, integral,
//    previous error, last count and the arrival flag, and reloads register defaults.
`default_nettype none
module encoder_position_pid #(
    parameter int unsigned COUNTER_WIDTH      = 16,
    parameter int unsigned GAIN_FRACTION_BITS = 12
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [31:0]               cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [COUNTER_WIDTH-1:0]  s_counter_value,
    input  wire logic                      s_start_move,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [15:0]                    m_drive_magnitude,
    output logic [1:0]                     m_drive_direction,
    output logic                           m_arrived,
    output logic signed [31:0]             m_position_now
);
    import epid_pkg::*;

    epid_cfg_t                cfg_reg;
    logic                     in_valid_reg;
    logic [COUNTER_WIDTH-1:0] in_counter_reg;
    logic                     in_start_reg;

    logic       st_in_ready;
    logic       st_valid;
    epid_err_t  st_data;
    logic       mul_in_ready;
    logic       prod_valid;
    epid_prod_t prod_data;
    logic       drv_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain          <= KP_RESET;
            cfg_reg.ki_gain          <= KI_RESET;
            cfg_reg.kd_gain          <= KD_RESET;
            cfg_reg.drive_limit      <= LIMIT_RESET;
            cfg_reg.min_drive        <= MIN_RESET;
            cfg_reg.target_position  <= '0;
            cfg_reg.count_invert     <= 1'b0;
            cfg_reg.arrive_tolerance <= TOL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KP:     cfg_reg.kp_gain          <= cfg_wdata[GAIN_W-1:0];
                REG_KI:     cfg_reg.ki_gain          <= cfg_wdata[GAIN_W-1:0];
                REG_KD:     cfg_reg.kd_gain          <= cfg_wdata[GAIN_W-1:0];
                REG_LIMIT:  cfg_reg.drive_limit      <= cfg_wdata[GAIN_W-1:0];
                REG_MIN:    cfg_reg.min_drive        <= cfg_wdata[GAIN_W-1:0];
                REG_TARGET: cfg_reg.target_position  <= signed'(cfg_wdata[POS_W-1:0]);
                REG_INVERT: cfg_reg.count_invert     <= cfg_wdata[0];
                REG_TOL:    cfg_reg.arrive_tolerance <= cfg_wdata[7:0];
                default:    cfg_reg.count_invert     <= cfg_reg.count_invert;
            endcase
        end
    end

    assign s_ready = !in_valid_reg || st_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_counter_reg <= s_counter_value;
            in_start_reg   <= s_start_move;
        end
    end

    epid_state #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (in_valid_reg),
        .in_counter (in_counter_reg),
        .in_start   (in_start_reg),
        .in_ready   (st_in_ready),
        .st_valid   (st_valid),
        .st_data    (st_data),
        .st_ready   (mul_in_ready)
    );

    epid_mul u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (st_valid),
        .in_data    (st_data),
        .in_ready   (mul_in_ready),
        .prod_valid (prod_valid),
        .prod_data  (prod_data),
        .prod_ready (drv_in_ready)
    );

    epid_drive #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_drive (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (prod_valid),
        .in_data       (prod_data),
        .in_ready      (drv_in_ready),
        .out_valid     (m_valid),
        .out_magnitude (m_drive_magnitude),
        .out_direction (m_drive_direction),
        .out_arrived   (m_arrived),
        .out_position   (m_position_now),
        .out_ready     (m_ready)
    );

    a_arrived_is_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arrived |-> m_drive_magnitude == '0 && m_drive_direction == DIR_STOP)
        else $error("arrived beat without stop");

    a_moving_not_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_arrived |-> m_drive_direction == DIR_FWD
                               || m_drive_direction == DIR_REV)
        else $error("moving beat reports stop");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule
`default_nettype wire

### tb/encoder_position_pid_test.sv
`timescale 1ns / 1ps
// encoder_position_pid_test: self-checking bench for the encoder position PID block.
// Drives encoder ticks and register settings, and checks every result beat against
// an in-bench PID model. Depends on epid_pkg and encoder_position_pid.
module encoder_position_pid_test;
    import epid_pkg::*;

    localparam int FRAC = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 75;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    localparam epid_cfg_t RESET_CFG = '{
        kp_gain: KP_RESET, ki_gain: KI_RESET, kd_gain: KD_RESET,
        drive_limit: LIMIT_RESET, min_drive: MIN_RESET, target_position: 32'sd0,
        count_invert: 1'b0, arrive_tolerance: TOL_RESET
    };

    typedef struct packed {
        logic [15:0]        magnitude;
        logic [1:0]         direction;
        logic               arrived;
        logic signed [31:0] position;
    } drive_beat_t;

    class drive_tracker;
        epid_cfg_t          cfg;
        logic [15:0]        last_count;
        logic signed [31:0] position;
        longint             integ;
        longint             prev_err;
        bit                 holding;
        drive_beat_t        drive_due[$];
        int                 errors;
        int                 checked;
        int                 arrivals;

        function void clear();
            cfg = RESET_CFG;
            last_count = '0;
            position = '0;
            integ = 0;
            prev_err = 0;
            holding = 1'b0;
        endfunction

        function void set_reg(epid_reg_t idx, logic [31:0] v);
            case (idx)
                REG_KP:     cfg.kp_gain = v[15:0];
                REG_KI:     cfg.ki_gain = v[15:0];
                REG_KD:     cfg.kd_gain = v[15:0];
                REG_LIMIT:  cfg.drive_limit = v[15:0];
                REG_MIN:    cfg.min_drive = v[15:0];
                REG_TARGET: cfg.target_position = v;
                REG_INVERT: cfg.count_invert = v[0];
                REG_TOL:    cfg.arrive_tolerance = v[7:0];
                default:    ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function drive_beat_t next_drive(logic [15:0] cnt, logic start);
            drive_beat_t r;
            logic [15:0] delta;
            longint step, pos, tgt, err_full, err, lim, deriv, sum, slim, mag, aerr;
            if (start) begin
                position = '0;
                integ = 0;
                prev_err = 0;
                holding = 1'b0;
                last_count = cnt;
            end
            r.position = position;
            if (holding) begin
                r.magnitude = '0;
                r.direction = DIR_STOP;
                r.arrived = 1'b1;
                return r;
            end
            delta = cnt - last_count;
            step = longint'($signed(delta));
            if (cfg.count_invert) step = -step;
            last_count = cnt;
            position = position + step[31:0];
            pos = longint'(position);
            tgt = longint'($signed(cfg.target_position));
            err_full = tgt - pos;
            err = clip(err_full, S32_MIN, S32_MAX);
            lim = longint'(cfg.drive_limit);
            integ = clip(integ + err, -lim, lim);
            deriv = err - prev_err;
            prev_err = err;
            sum = longint'(cfg.kp_gain) * err + longint'(cfg.ki_gain) * integ
                + longint'(cfg.kd_gain) * deriv;
            slim = lim <<< FRAC;
            sum = clip(sum, -slim, slim);
            mag = (sum < 0 ? -sum : sum) >>> FRAC;
            if (mag < longint'(cfg.min_drive)) mag = longint'(cfg.min_drive);
            else if (mag > lim) mag = lim;
            aerr = err_full < 0 ? -err_full : err_full;
            r.position = position;
            if (aerr < longint'(cfg.arrive_tolerance)) begin
                holding = 1'b1;
                r.magnitude = '0;
                r.direction = DIR_STOP;
                r.arrived = 1'b1;
            end else begin
                r.magnitude = mag[15:0];
                r.direction = (pos < tgt) ? DIR_FWD : DIR_REV;
                r.arrived = 1'b0;
            end
            return r;
        endfunction

        function void note_tick(logic [15:0] cnt, logic start);
            drive_due.push_back(next_drive(cnt, start));
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_drive(drive_beat_t got);
            drive_beat_t want;
            if (drive_due.size() == 0) begin
                report($sformatf("result beat with nothing pending, position %0d",
                                 got.position));
            end else begin
                want = drive_due.pop_front();
                checked++;
                if (want.arrived) arrivals++;
                if (got.magnitude !== want.magnitude)
                    report($sformatf("beat %0d magnitude %0d, want %0d",
                                     checked, got.magnitude, want.magnitude));
                if (got.direction !== want.direction)
                    report($sformatf("beat %0d direction %0d, want %0d",
                                     checked, got.direction, want.direction));
                if (got.arrived !== want.arrived)
                    report($sformatf("beat %0d arrived %0b, want %0b",
                                     checked, got.arrived, want.arrived));
                if (got.position !== want.position)
                    report($sformatf("beat %0d position %0d, want %0d",
                                     checked, got.position, want.position));
            end
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [15:0]        s_counter_value = '0;
    logic               s_start_move = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_drive_magnitude;
    logic [1:0]         m_drive_direction;
    logic               m_arrived;
    logic signed [31:0] m_position_now;

    drive_tracker tracker;
    drive_beat_t  seen_beat;
    bit           gaps_on = 1'b1;
    int           stalled = 0;
    int           ticks_sent = 0;
    int           settings_used = 0;

    encoder_position_pid DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_counter_value   (s_counter_value),
        .s_start_move      (s_start_move),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_magnitude (m_drive_magnitude),
        .m_drive_direction (m_drive_direction),
        .m_arrived         (m_arrived),
        .m_position_now    (m_position_now)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: check each accepted beat, then pick next ready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_beat = {m_drive_magnitude, m_drive_direction, m_arrived, m_position_now};
                tracker.check_drive(seen_beat);
            end
            m_ready <= !gaps_on || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stalled = 0;
            else stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("encoder_position_pid_test: done, errors");
                $finish;
            end
        end
    end

    task automatic send_tick(logic [15:0] cnt, logic start);
        while (gaps_on && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_counter_value <= cnt;
        s_start_move <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_tick(cnt, start);
        ticks_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.drive_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apply_setting(epid_cfg_t c);
        epid_reg_t   idx;
        logic [31:0] v;
        idx = idx.first();
        do begin
            case (idx)
                REG_KP:     v = 32'(c.kp_gain);
                REG_KI:     v = 32'(c.ki_gain);
                REG_KD:     v = 32'(c.kd_gain);
                REG_LIMIT:  v = 32'(c.drive_limit);
                REG_MIN:    v = 32'(c.min_drive);
                REG_TARGET: v = c.target_position;
                REG_INVERT: v = 32'(c.count_invert);
                default:    v = 32'(c.arrive_tolerance);
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= v;
            @(posedge aclk);
            tracker.set_reg(idx, v);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(6000));
        endcase
    endfunction

    function automatic epid_cfg_t random_setting();
        epid_cfg_t c;
        c.kp_gain = pick16();
        c.ki_gain = pick16();
        c.kd_gain = pick16();
        c.drive_limit = pick16();
        c.min_drive = ($urandom_range(2) == 0) ? pick16()
                                               : 16'($urandom_range(c.drive_limit));
        case ($urandom_range(7))
            0: c.target_position = 32'h7FFF_FFFF;
            1: c.target_position = 32'h8000_0000;
            default: c.target_position = 32'($urandom_range(40000)) - 32'd20000;
        endcase
        c.count_invert = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: c.arrive_tolerance = 8'd0;
            1: c.arrive_tolerance = 8'd255;
            default: c.arrive_tolerance = 8'($urandom_range(40));
        endcase
        return c;
    endfunction

    // mostly moves that step toward the target, with restarts and raw noise mixed in
    task automatic run_moves(int count);
        int          n;
        int          frozen;
        longint      gap, step, reach;
        logic [15:0] cnt;
        n = 1;
        frozen = 0;
        send_tick(16'($urandom), 1'b1);
        while (n < count) begin
            if (tracker.holding && frozen < int'($urandom_range(3))) begin
                frozen++;
                send_tick(16'($urandom), 1'b0);
            end else begin
                frozen = 0;
                if (tracker.holding || $urandom_range(99) < 3) begin
                    send_tick(16'($urandom), 1'b1);
                end else if ($urandom_range(99) < 12) begin
                    send_tick(16'($urandom), 1'b0);
                end else begin
                    gap = longint'($signed(tracker.cfg.target_position))
                        - longint'(tracker.position);
                    reach = $urandom_range(4000, 1);
                    step = tracker.clip(gap, -reach, reach);
                    if ($urandom_range(3) == 0) step += longint'($urandom_range(20)) - 10;
                    if (tracker.cfg.count_invert) step = -step;
                    cnt = tracker.last_count + step[15:0];
                    send_tick(cnt, 1'b0);
                end
                n++;
            end
        end
    endtask

    initial begin
        epid_cfg_t c;
        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        tracker.clear();

        // reset settings: on target at once, then held
        send_tick(16'd0, 1'b1);
        send_tick(16'hFFFF, 1'b0);
        drain();

        // counter wrap in both directions, both half-range steps, arrival and restart
        c = RESET_CFG;
        c.target_position = 32'sd1000;
        apply_setting(c);
        send_tick(16'hFFF0, 1'b1);
        send_tick(16'h0010, 1'b0);
        send_tick(16'h8010, 1'b0);
        send_tick(16'h800F, 1'b0);
        send_tick(16'h000E, 1'b0);
        send_tick(16'd982, 1'b0);
        send_tick(16'd0, 1'b0);
        send_tick(16'd0, 1'b1);
        drain();

        // inverted count, full gains, error beyond 32 bits above
        c.count_invert = 1'b1;
        c.kp_gain = 16'hFFFF;
        c.ki_gain = 16'hFFFF;
        c.kd_gain = 16'hFFFF;
        c.drive_limit = 16'hFFFF;
        c.min_drive = 16'd0;
        c.target_position = 32'h7FFF_FFFF;
        c.arrive_tolerance = 8'd255;
        apply_setting(c);
        send_tick(16'h1234, 1'b1);
        send_tick(16'h1234 + 16'd1000, 1'b0);
        send_tick(16'h1234 + 16'd1000 + 16'h8000, 1'b0);
        drain();

        // error beyond 32 bits below, min drive above the limit, zero tolerance
        c.count_invert = 1'b0;
        c.drive_limit = 16'd50;
        c.min_drive = 16'hFFFF;
        c.target_position = 32'h8000_0000;
        c.arrive_tolerance = 8'd0;
        apply_setting(c);
        send_tick(16'd0, 1'b1);
        send_tick(16'd500, 1'b0);
        drain();

        // zero gains and limit; sitting on target without arriving reads reverse
        c.kp_gain = '0;
        c.ki_gain = '0;
        c.kd_gain = '0;
        c.drive_limit = '0;
        c.min_drive = '0;
        c.target_position = '0;
        apply_setting(c);
        send_tick(16'd0, 1'b1);
        send_tick(16'd7, 1'b0);
        send_tick(16'hFFF9, 1'b0);
        drain();

        c = RESET_CFG;
        c.count_invert = 1'b1;
        c.target_position = -32'sd300;
        c.arrive_tolerance = 8'd255;
        apply_setting(c);
        send_tick(16'h00FF, 1'b1);
        send_tick(16'h00FF + 16'd100, 1'b0);
        send_tick(16'h5A5A, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            gaps_on = (p != 3);
            apply_setting(random_setting());
            run_moves(TICKS_PER_PHASE);
            drain();
        end

        $display("run covered %0d encoder ticks under %0d register settings",
                 ticks_sent, settings_used);
        $display("%0d result beats checked, %0d of them stop beats after arrival",
                 tracker.checked, tracker.arrivals);
        if (tracker.errors == 0) begin
            $display("encoder_position_pid_test: done, clean");
        end else begin
            $display("encoder_position_pid_test: done, errors");
        end
        $finish;
    end
endmodule
